FILE: src/prast_pkg.sv
// Package for the per-round arrival statistics table: field widths, outcome codes,
// controller states and the packed entry and result layouts.
// No dependencies.
package prast_pkg;

    localparam int ROUND_W   = 32;
    localparam int BYTES_W   = 16;
    localparam int TIME_W    = 48;
    localparam int COUNT_W   = 32;
    localparam int TOTAL_W   = 48;
    localparam int DELAY_W   = 64;
    localparam int SLOT_W    = 6;
    localparam int OUTCOME_W = 2;

    // s_tdata: round_number, record_bytes, arrival_us, sent_us (144 bits, 18 bytes)
    localparam int IN_W  = ROUND_W + BYTES_W + 2 * TIME_W;
    // m_tdata: outcome .. earliest_sent_us (296 bits, 37 bytes)
    localparam int OUT_W = OUTCOME_W + SLOT_W + COUNT_W + TOTAL_W + DELAY_W + 3 * TIME_W;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_UPDATED  = 2'd0,
        OUT_INSERTED = 2'd1,
        OUT_DROPPED  = 2'd2
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    // One table entry apart from its round tag
    typedef struct packed {
        logic [TIME_W-1:0]  min_sent;
        logic [TIME_W-1:0]  last_time;
        logic [TIME_W-1:0]  first_time;
        logic [DELAY_W-1:0] delay_total;
        logic [TOTAL_W-1:0] byte_total;
        logic [COUNT_W-1:0] arrival_count;
    } stats_t;

    // Result item, outcome in the lowest bits
    typedef struct packed {
        logic [TIME_W-1:0]  earliest_sent_us;
        logic [TIME_W-1:0]  last_arrival_us;
        logic [TIME_W-1:0]  first_arrival_us;
        logic [DELAY_W-1:0] delay_sum_us;
        logic [TOTAL_W-1:0] bytes_seen;
        logic [COUNT_W-1:0] arrivals_seen;
        logic [SLOT_W-1:0]  entry_slot;
        outcome_t           outcome;
    } result_t;

endpackage

FILE: src/prast_store.sv
// Table storage: round tag memory and entry statistics memory, one write port
// and one registered read port each. Uses prast_pkg for the entry layout.
module prast_store #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic                         clk,
    input  logic                         tag_rd_en,
    input  logic [IDX_W-1:0]             tag_rd_addr,
    output logic [prast_pkg::ROUND_W-1:0] tag_rd_data,
    input  logic                         stats_rd_en,
    input  logic [IDX_W-1:0]             stats_rd_addr,
    output prast_pkg::stats_t            stats_rd_data,
    input  logic                         wr_en,
    input  logic                         wr_tag_en,
    input  logic [IDX_W-1:0]             wr_addr,
    input  logic [prast_pkg::ROUND_W-1:0] wr_tag,
    input  prast_pkg::stats_t            wr_stats
);

    logic [prast_pkg::ROUND_W-1:0] tag_mem [DEPTH];
    prast_pkg::stats_t             stats_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_tag_en)
        begin
            tag_mem[wr_addr] <= wr_tag;
        end
        if (tag_rd_en)
        begin
            tag_rd_data <= tag_mem[tag_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stats_mem[wr_addr] <= wr_stats;
        end
        if (stats_rd_en)
        begin
            stats_rd_data <= stats_mem[stats_rd_addr];
        end
    end

endmodule

FILE: src/per_round_arrival_stats_table.sv
// Top level of the per-round arrival statistics table: scan controller, update
// logic and output register. Uses prast_pkg and prast_store.
//
//   channel   | direction | tdata fields (lowest bit first)
//   ----------+-----------+-----------------------------------------------------
//   s_axis    | in        | round_number, record_bytes, arrival_us, sent_us
//   m_axis    | out       | outcome, entry_slot, arrivals_seen, bytes_seen,
//             |           | delay_sum_us, first_arrival_us, last_arrival_us,
//             |           | earliest_sent_us
//
// An item is accepted, the tags of the used entries are read in turn through the tag
// memory's single read port and compared with its round, and then the entry is updated
// and the output register loaded. A hit ends the scan early. No item is taken until
// the previous one is in the output register; a stalled output holds the update step.
// After reset the table is empty and usable at once: no clearing pass.
module per_round_arrival_stats_table #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,  // round_number, record_bytes, arrival_us, sent_us
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [295:0] m_tdata   // outcome, entry_slot, arrivals_seen, bytes_seen,
                                   // delay_sum_us, first_arrival_us, last_arrival_us,
                                   // earliest_sent_us
);

    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int ROUND_W = prast_pkg::ROUND_W;
    localparam int BYTES_W = prast_pkg::BYTES_W;
    localparam int TIME_W  = prast_pkg::TIME_W;
    localparam int COUNT_W = prast_pkg::COUNT_W;
    localparam int TOTAL_W = prast_pkg::TOTAL_W;
    localparam int DELAY_W = prast_pkg::DELAY_W;
    localparam int SLOT_W  = prast_pkg::SLOT_W;

    prast_pkg::state_t    state_reg, state_next;
    logic [ROUND_W-1:0]   round_reg, round_next;
    logic [BYTES_W-1:0]   bytes_reg, bytes_next;
    logic [TIME_W-1:0]    arrival_reg, arrival_next;
    logic [TIME_W-1:0]    sent_reg, sent_next;
    logic [DELAY_W-1:0]   delay_reg, delay_next;
    logic [CNT_W-1:0]     used_reg, used_next;
    logic [CNT_W-1:0]     issue_reg, issue_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                 hit_reg, hit_next;
    logic                 out_valid_reg, out_valid_next;
    prast_pkg::result_t   result_reg, result_next;

    logic                 tag_rd_en;
    logic [IDX_W-1:0]     tag_rd_addr;
    logic [ROUND_W-1:0]   tag_rd_data;
    logic                 stats_rd_en;
    prast_pkg::stats_t    stats_rd_data;
    logic                 wr_en;
    logic                 wr_tag_en;
    logic [IDX_W-1:0]     wr_addr;
    prast_pkg::stats_t    wr_stats;
    logic                 tag_match;

    prast_store #(
        .DEPTH (TABLE_ENTRIES),
        .IDX_W (IDX_W)
    ) u_store (
        .clk           (clk),
        .tag_rd_en     (tag_rd_en),
        .tag_rd_addr   (tag_rd_addr),
        .tag_rd_data   (tag_rd_data),
        .stats_rd_en   (stats_rd_en),
        .stats_rd_addr (cmp_idx_reg),
        .stats_rd_data (stats_rd_data),
        .wr_en         (wr_en),
        .wr_tag_en     (wr_tag_en),
        .wr_addr       (wr_addr),
        .wr_tag        (round_reg),
        .wr_stats      (wr_stats)
    );

    assign s_tready  = (state_reg == prast_pkg::ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = result_reg;
    assign tag_match = cmp_valid_reg && (tag_rd_data == round_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= prast_pkg::ST_IDLE;
            used_reg      <= '0;
            issue_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        round_reg   <= round_next;
        bytes_reg   <= bytes_next;
        arrival_reg <= arrival_next;
        sent_reg    <= sent_next;
        delay_reg   <= delay_next;
        cmp_idx_reg <= cmp_idx_next;
        result_reg  <= result_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        bytes_next     = bytes_reg;
        arrival_next   = arrival_reg;
        sent_next      = sent_reg;
        delay_next     = delay_reg;
        used_next      = used_reg;
        issue_next     = issue_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        hit_next       = hit_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !m_tready;

        tag_rd_en   = 1'b0;
        tag_rd_addr = issue_reg[IDX_W-1:0];
        stats_rd_en = 1'b0;
        wr_en       = 1'b0;
        wr_tag_en   = 1'b0;
        wr_addr     = cmp_idx_reg;
        wr_stats    = stats_rd_data;

        unique case (state_reg)
            prast_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    round_next     = s_tdata[31:0];
                    bytes_next     = s_tdata[47:32];
                    arrival_next   = s_tdata[95:48];
                    sent_next      = s_tdata[143:96];
                    delay_next     = DELAY_W'(s_tdata[95:48]) - DELAY_W'(s_tdata[143:96]);
                    issue_next     = '0;
                    cmp_valid_next = 1'b0;
                    state_next     = prast_pkg::ST_SCAN;
                end
            end

            prast_pkg::ST_SCAN:
            begin
                // compare the tag read last cycle; on a miss the next one is fetched if any remain
                if (tag_match)
                begin
                    hit_next    = 1'b1;
                    stats_rd_en = 1'b1;
                    state_next  = prast_pkg::ST_UPDATE;
                end
                else if (issue_reg < used_reg)
                begin
                    tag_rd_en      = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_reg[IDX_W-1:0];
                    issue_next     = issue_reg + CNT_W'(1);
                end
                else
                begin
                    hit_next       = 1'b0;
                    cmp_valid_next = 1'b0;
                    state_next     = prast_pkg::ST_UPDATE;
                end
            end

            prast_pkg::ST_UPDATE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    if (hit_reg)
                    begin
                        wr_stats.arrival_count = stats_rd_data.arrival_count + COUNT_W'(1);
                        wr_stats.byte_total    = stats_rd_data.byte_total + TOTAL_W'(bytes_reg);
                        wr_stats.delay_total   = stats_rd_data.delay_total + delay_reg;
                        wr_stats.first_time    = stats_rd_data.first_time;
                        wr_stats.last_time     = arrival_reg;
                        wr_stats.min_sent      = (stats_rd_data.min_sent > sent_reg) ?
                                                 sent_reg : stats_rd_data.min_sent;
                        wr_en   = 1'b1;
                        wr_addr = cmp_idx_reg;
                        result_next.outcome    = prast_pkg::OUT_UPDATED;
                        result_next.entry_slot = SLOT_W'(cmp_idx_reg);
                    end
                    else if (used_reg < CNT_W'(TABLE_ENTRIES))
                    begin
                        wr_stats.arrival_count = COUNT_W'(1);
                        wr_stats.byte_total    = TOTAL_W'(bytes_reg);
                        wr_stats.delay_total   = delay_reg;
                        wr_stats.first_time    = arrival_reg;
                        wr_stats.last_time     = arrival_reg;
                        wr_stats.min_sent      = sent_reg;
                        wr_en     = 1'b1;
                        wr_tag_en = 1'b1;
                        wr_addr   = used_reg[IDX_W-1:0];
                        used_next = used_reg + CNT_W'(1);
                        result_next.outcome    = prast_pkg::OUT_INSERTED;
                        result_next.entry_slot = SLOT_W'(used_reg[IDX_W-1:0]);
                    end
                    else
                    begin
                        // table full and no match: drop, all fields zero
                        wr_stats = '0;
                        result_next.outcome    = prast_pkg::OUT_DROPPED;
                        result_next.entry_slot = '0;
                    end
                    result_next.arrivals_seen    = wr_stats.arrival_count;
                    result_next.bytes_seen       = wr_stats.byte_total;
                    result_next.delay_sum_us     = wr_stats.delay_total;
                    result_next.first_arrival_us = wr_stats.first_time;
                    result_next.last_arrival_us  = wr_stats.last_time;
                    result_next.earliest_sent_us = wr_stats.min_sent;
                    out_valid_next = 1'b1;
                    state_next     = prast_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = prast_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/prast_chk.sv
// Port-level checks for the per-round arrival statistics table, with the bind
// that attaches them to the top level. Depends on per_round_arrival_stats_table.
module prast_chk (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [143:0] s_tdata,  // round_number, record_bytes, arrival_us, sent_us
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [295:0] m_tdata   // outcome, entry_slot, arrivals_seen, bytes_seen,
                                  // delay_sum_us, first/last_arrival_us, earliest_sent_us
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // a dropped item carries only its outcome
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == 2'd2) |-> (m_tdata[295:2] == '0))
        else $error("dropped item with nonzero fields");

    // a new entry has seen one record, first and last arrival agree
    a_insert_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == 2'd1) |->
            (m_tdata[39:8] == 32'd1) && (m_tdata[199:152] == m_tdata[247:200]))
        else $error("inserted entry not fresh");

    // the outcome code 3 never appears
    a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] != 2'd3))
        else $error("undefined outcome code");

endmodule

bind per_round_arrival_stats_table prast_chk u_prast_chk (.*);

FILE: tb/sv/tb_top.sv
// Testbench for per_round_arrival_stats_table: drives records on s_axis, predicts each
// result from its own copy of the round table and checks every m_axis item field by field.
// Depends on prast_pkg and the block's RTL.
module tb_top;
    import prast_pkg::*;

    localparam int TABLE_ENTRIES  = 64;
    localparam int RANDOM_RECORDS = 1032;
    localparam int IDLE_LIMIT     = 4000;
    localparam int DRAIN_CYCLES   = 100;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // One input item, round_number in the lowest bits
    typedef struct packed {
        logic [TIME_W-1:0]  sent_us;
        logic [TIME_W-1:0]  arrival_us;
        logic [BYTES_W-1:0] record_bytes;
        logic [ROUND_W-1:0] round_number;
    } record_t;

    class arrival_stats_scoreboard;
        logic [ROUND_W-1:0] round_tags [TABLE_ENTRIES];
        stats_t             round_stats [TABLE_ENTRIES];
        int                 rounds_used;
        result_t            expected_results [$];
        int                 errors;

        function new();
            rounds_used = 0;
            errors      = 0;
        endfunction

        function void log_record(record_t rec);
            logic [DELAY_W-1:0] delay;
            result_t            exp_res;
            int                 slot;
            int                 i;
            delay   = DELAY_W'(rec.arrival_us) - DELAY_W'(rec.sent_us);
            exp_res = '0;
            slot    = -1;
            for (i = 0; i < rounds_used; i++)
            begin
                if (slot < 0 && round_tags[i] == rec.round_number)
                    slot = i;
            end
            if (slot >= 0)
            begin
                round_stats[slot].arrival_count = round_stats[slot].arrival_count + 1'b1;
                round_stats[slot].byte_total    = round_stats[slot].byte_total
                                                  + TOTAL_W'(rec.record_bytes);
                round_stats[slot].delay_total   = round_stats[slot].delay_total + delay;
                round_stats[slot].last_time     = rec.arrival_us;
                if (round_stats[slot].min_sent > rec.sent_us)
                    round_stats[slot].min_sent = rec.sent_us;
                exp_res.outcome = OUT_UPDATED;
            end
            else if (rounds_used < TABLE_ENTRIES)
            begin
                slot = rounds_used;
                rounds_used++;
                round_tags[slot]                = rec.round_number;
                round_stats[slot].arrival_count = COUNT_W'(1);
                round_stats[slot].byte_total    = TOTAL_W'(rec.record_bytes);
                round_stats[slot].delay_total   = delay;
                round_stats[slot].first_time    = rec.arrival_us;
                round_stats[slot].last_time     = rec.arrival_us;
                round_stats[slot].min_sent      = rec.sent_us;
                exp_res.outcome = OUT_INSERTED;
            end
            if (slot >= 0)
            begin
                exp_res.entry_slot       = SLOT_W'(slot);
                exp_res.arrivals_seen    = round_stats[slot].arrival_count;
                exp_res.bytes_seen       = round_stats[slot].byte_total;
                exp_res.delay_sum_us     = round_stats[slot].delay_total;
                exp_res.first_arrival_us = round_stats[slot].first_time;
                exp_res.last_arrival_us  = round_stats[slot].last_time;
                exp_res.earliest_sent_us = round_stats[slot].min_sent;
            end
            else
                exp_res.outcome = OUT_DROPPED;
            expected_results = {expected_results, exp_res};
        endfunction

        function void compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
            if (act_val !== exp_val)
            begin
                $error("%s: expected %0h, got %0h", name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_W-1:0] raw);
            result_t act, exp_res;
            act = result_t'(raw);
            if (expected_results.size() == 0)
            begin
                $error("result item with no record pending: %h", raw);
                errors++;
                return;
            end
            exp_res = expected_results[0];
            expected_results.delete(0);
            compare_field("outcome", 64'(exp_res.outcome), 64'(act.outcome));
            compare_field("entry_slot", 64'(exp_res.entry_slot), 64'(act.entry_slot));
            compare_field("arrivals_seen", 64'(exp_res.arrivals_seen), 64'(act.arrivals_seen));
            compare_field("bytes_seen", 64'(exp_res.bytes_seen), 64'(act.bytes_seen));
            compare_field("delay_sum_us", exp_res.delay_sum_us, act.delay_sum_us);
            compare_field("first_arrival_us", 64'(exp_res.first_arrival_us),
                          64'(act.first_arrival_us));
            compare_field("last_arrival_us", 64'(exp_res.last_arrival_us),
                          64'(act.last_arrival_us));
            compare_field("earliest_sent_us", 64'(exp_res.earliest_sent_us),
                          64'(act.earliest_sent_us));
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;   // round_number, record_bytes, arrival_us, sent_us
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;        // outcome, entry_slot, arrivals_seen, bytes_seen,
                                      // delay_sum_us, first_arrival_us, last_arrival_us,
                                      // earliest_sent_us

    arrival_stats_scoreboard tables = new();
    logic [ROUND_W-1:0]      known_rounds [$];
    bit                      calm = 1'b0;
    int                      quiet_cycles = 0;

    per_round_arrival_stats_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one; none while calm
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic record_t make_record(logic [ROUND_W-1:0] round_number,
                                            logic [BYTES_W-1:0] record_bytes,
                                            logic [TIME_W-1:0] arrival_us,
                                            logic [TIME_W-1:0] sent_us);
        record_t rec;
        rec.round_number = round_number;
        rec.record_bytes = record_bytes;
        rec.arrival_us   = arrival_us;
        rec.sent_us      = sent_us;
        return rec;
    endfunction

    function automatic record_t random_record(int fresh_pct);
        record_t            rec;
        logic [ROUND_W-1:0] near;
        rec.round_number = $urandom;
        if (known_rounds.size() != 0 && $urandom_range(0, 99) >= fresh_pct)
            rec.round_number = known_rounds[$urandom_range(0, known_rounds.size() - 1)];
        else if (known_rounds.size() != 0 && $urandom_range(0, 3) == 0)
        begin
            // near miss: one bit away from a used round
            near = known_rounds[$urandom_range(0, known_rounds.size() - 1)];
            rec.round_number = near ^ (32'd1 << $urandom_range(0, 31));
        end
        case ($urandom_range(0, 9))
            0:       rec.record_bytes = '0;
            1:       rec.record_bytes = '1;
            default: rec.record_bytes = BYTES_W'($urandom);
        endcase
        rec.arrival_us = TIME_W'({$urandom, $urandom});
        case ($urandom_range(0, 19))
            0, 1, 2: rec.sent_us = TIME_W'({$urandom, $urandom});
            3, 4:    rec.sent_us = rec.arrival_us + TIME_W'($urandom_range(0, 5000));
            default: rec.sent_us = rec.arrival_us - TIME_W'($urandom_range(0, 5000));
        endcase
        return rec;
    endfunction

    task automatic drive_record(input record_t rec);
        int gap;
        bit known;
        gap   = pick_gap();
        known = 1'b0;
        foreach (known_rounds[i])
        begin
            if (known_rounds[i] == rec.round_number)
                known = 1'b1;
        end
        if (!known && known_rounds.size() < TABLE_ENTRIES)
            known_rounds = {known_rounds, rec.round_number};
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rec;
        do
            @(posedge clk);
        while (!s_tready);
        tables.log_record(rec);
        @(negedge clk);
    endtask

    initial
    begin : result_sink
        int stall;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    // Check results and end a run that stops moving
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tables.check_result(m_tdata);
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        int phase;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        drive_record(make_record('0, '0, '0, '0));
        drive_record(make_record('0, '1, TIME_MAX, '0));
        // send after arrival: most negative delay
        drive_record(make_record('0, 16'd1, '0, TIME_MAX));
        drive_record(make_record('0, 16'd7, 48'd100, '0));
        drive_record(make_record('1, '1, TIME_MAX, TIME_MAX));
        // equal send time keeps the minimum, a smaller one replaces it
        drive_record(make_record('1, '1, TIME_MAX, TIME_MAX));
        drive_record(make_record('1, 16'h8000, 48'd5, TIME_MAX - 1'b1));
        drive_record(make_record(32'd1, 16'h5555, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA));
        drive_record(make_record(32'h8000_0000, 16'hAAAA, 48'hAAAA_AAAA_AAAA,
                                 48'h5555_5555_5555));
        drive_record(make_record(32'd1, '1, 48'h8000_0000_0000, 48'h0000_0000_0001));
        drive_record(make_record(32'h8000_0001, '0, 48'd1, 48'd2));
        drive_record(make_record('0, '1, TIME_MAX, TIME_MAX));
        drive_record(make_record(32'h7FFF_FFFF, 16'h0001, 48'h7FFF_FFFF_FFFF, '0));

        // fill the table early, then mostly hits with a share of drops
        for (phase = 0; phase < 4; phase++)
        begin
            calm = (phase == 2);
            repeat (RANDOM_RECORDS / 4)
                drive_record(random_record(phase == 0 ? 45 : 12));
        end
        s_tvalid <= 1'b0;

        while (tables.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tables.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

FILE: per_round_arrival_stats_table.f
src/prast_pkg.sv
src/prast_store.sv
src/per_round_arrival_stats_table.sv
src/prast_chk.sv
tb/sv/tb_top.sv
